@@ rtl/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, quiet during reset
`define TPVL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define TPVL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tpvl_pkg.sv @@
package tpvl_pkg;

  // field widths
  localparam int VEL_W   = 16;
  localparam int TICK_W  = 32;
  localparam int GAIN_W  = 32;
  localparam int OUT_W   = 32;

  // internal arithmetic widths
  localparam int ERR_W   = VEL_W + 1;
  localparam int ACC_W   = 48;
  localparam int FRAC_W  = 16;

  // shift-add multiplier and restoring divider
  localparam int MCAND_W   = ACC_W;
  localparam int MPLR_W    = GAIN_W;
  localparam int PROD_W    = MCAND_W + MPLR_W;
  localparam int MUL_STEPS = MPLR_W;
  localparam int DIV_W     = 48;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W     = 6;

  // term limits
  localparam int P_W      = 34;
  localparam int D_W      = 34;
  localparam int I_MAG_W  = 61;
  localparam int I_W      = I_MAG_W + 1;
  localparam int SUM_W    = 63;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

endpackage

@@ rtl/tpvl_if.sv @@
// request channel into the loop
interface tpvl_in_if;
  import tpvl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  measured_velocity;
  logic        [TICK_W-1:0] sample_tick;
  logic signed [VEL_W-1:0]  target_velocity;
  logic        [TICK_W-1:0] output_tick;

  modport source (output valid, output measured_velocity, output sample_tick,
                  output target_velocity, output output_tick, input ready);
  modport sink   (input valid, input measured_velocity, input sample_tick,
                  input target_velocity, input output_tick, output ready);
endinterface

// result channel out of the loop
interface tpvl_out_if;
  import tpvl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] drive_value;
  logic                    sum_saturated;
  logic                    zero_interval;

  modport source (output valid, output drive_value, output sum_saturated,
                  output zero_interval, input ready);
  modport sink   (input valid, input drive_value, input sum_saturated,
                  input zero_interval, output ready);
endinterface

@@ rtl/timestamped_pid_velocity_loop.sv @@
// Time-weighted PID velocity loop. Each request carries a velocity sample with its tick,
// a target and the tick at which the drive value is wanted; one drive value comes back per
// request. All products go through one shift-add multiplier that retires one multiplier
// bit per cycle, and the derivative quotient through a restoring divider that retires one
// quotient bit per cycle. Each product passes through set-up, 32 steps and take-up, the
// divide through 48 steps and the floor shift, and the sum through a final step. A request
// with a zero velocity sample stops after the proportional product, and one with a zero
// stamp difference after the integral product. One request is worked on at a time: the
// next request is taken once the previous sum has gone into the output register; it is
// taken while the previous result still waits in that register, and a finished sum waits
// until that register is free. Gains are signed Q16.16 and are written through the plain
// write port; the user must write them only while idle, which the block does not enforce.
`include "assert_macros.svh"

module timestamped_pid_velocity_loop (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tpvl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpvl_pkg::GAIN_W-1:0]    cfg_data,
  tpvl_in_if.sink                        in_ch,
  tpvl_out_if.source                     out_ch
);
  import tpvl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_POST, S_DIV, S_DPOST, S_SUM
  } state_t;

  typedef enum logic [1:0] {OP_P, OP_W, OP_I, OP_D} op_t;

  state_t state;
  op_t    op;

  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic signed [VEL_W-1:0]  cur_vel, old_vel;
  logic        [TICK_W-1:0] cur_stamp, prev_stamp;
  logic signed [ACC_W-1:0]  acc;

  logic signed [ERR_W-1:0]  err, dv;
  logic        [TICK_W-1:0] weight, dt;

  logic [MCAND_W-1:0] mcand, mul_hi;
  logic [MPLR_W-1:0]  mul_lo;
  logic               mul_neg;
  logic [CNT_W-1:0]   cnt;

  logic [TICK_W-1:0] div_rem;
  logic [DIV_W-1:0]  div_quo;
  logic              div_neg;

  logic signed [P_W-1:0] p_term;
  logic signed [I_W-1:0] i_term;
  logic signed [D_W-1:0] d_term;
  logic                  sat_acc, zdt;

  // combinational helpers
  logic                     in_take;
  logic                     out_load;
  logic signed [ERR_W-1:0]  err_in, dv_in;
  logic [MCAND_W:0]         mul_sum;
  logic [PROD_W-1:0]        mul_prod;
  logic [PROD_W-FRAC_W-1:0] mul_q;
  logic [ERR_W-1:0]         err_mag, dv_mag;
  logic [ACC_W-1:0]         acc_mag;
  logic [GAIN_W-1:0]        gp_mag, gi_mag, gd_mag;
  logic signed [ACC_W+1:0]  prod_s, acc_sum;
  logic                     acc_ovf;
  logic [I_MAG_W-1:0]       i_mag;
  logic [P_W-2:0]           p_mag;
  logic [TICK_W:0]          div_shift;
  logic [TICK_W+1:0]        div_diff;
  logic [D_W-2:0]           d_mag;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_ovf;

  assign in_ch.ready = (state == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_load    = (state == S_SUM) && (!out_ch.valid || out_ch.ready);

  // error and velocity change of the incoming request
  assign err_in = ERR_W'(in_ch.target_velocity) - ERR_W'(in_ch.measured_velocity);
  assign dv_in  = ERR_W'(in_ch.measured_velocity) - ERR_W'(cur_vel);

  // operand magnitudes
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign dv_mag  = dv[ERR_W-1] ? ERR_W'(-dv) : ERR_W'(dv);
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign gp_mag  = gain_p[GAIN_W-1] ? GAIN_W'(-gain_p) : GAIN_W'(gain_p);
  assign gi_mag  = gain_i[GAIN_W-1] ? GAIN_W'(-gain_i) : GAIN_W'(gain_i);
  assign gd_mag  = gain_d[GAIN_W-1] ? GAIN_W'(-gain_d) : GAIN_W'(gain_d);

  // shift-add step and floor shift of the signed product
  assign mul_sum  = mul_lo[0] ? ({1'b0, mul_hi} + {1'b0, mcand}) : {1'b0, mul_hi};
  assign mul_prod = {mul_hi, mul_lo};
  assign mul_q    = mul_prod[PROD_W-1:FRAC_W]
                  + (PROD_W-FRAC_W)'(mul_neg && (|mul_prod[FRAC_W-1:0]));

  // accumulator update, saturated to its signed range
  assign prod_s  = mul_neg ? -$signed({2'b00, mul_prod[ACC_W-1:0]})
                           : $signed({2'b00, mul_prod[ACC_W-1:0]});
  assign acc_sum = (ACC_W+2)'(acc) + prod_s;
  assign acc_ovf = (acc_sum[ACC_W+1] != acc_sum[ACC_W-1])
                || (acc_sum[ACC_W] != acc_sum[ACC_W-1]);

  // integral magnitude held within the term limit
  assign i_mag = (mul_q > (PROD_W-FRAC_W)'(1) << (I_MAG_W-1))
               ? I_MAG_W'(1) << (I_MAG_W-1) : mul_q[I_MAG_W-1:0];
  assign p_mag = mul_q[P_W-2:0];

  // restoring divide step
  assign div_shift = {div_rem, div_quo[DIV_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, dt};
  assign d_mag     = (D_W-1)'(div_quo[DIV_W-1:FRAC_W])
                   + (D_W-1)'(div_neg && (|div_quo[FRAC_W-1:0]));

  // final sum and output clamp
  assign sum     = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
  assign sum_ovf = !((&sum[SUM_W-1:OUT_W-1]) || !(|sum[SUM_W-1:OUT_W-1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_P;
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      cur_vel      <= '0;
      old_vel      <= '0;
      cur_stamp    <= '0;
      prev_stamp   <= '0;
      acc          <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // gain writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAIN_P: gain_p <= $signed(cfg_data);
          CFG_GAIN_I: gain_i <= $signed(cfg_data);
          CFG_GAIN_D: gain_d <= $signed(cfg_data);
          default: ;
        endcase
      end

      // output register: filled from a finished sum, emptied once taken downstream
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            old_vel    <= cur_vel;
            prev_stamp <= cur_stamp;
            cur_vel    <= in_ch.measured_velocity;
            cur_stamp  <= in_ch.sample_tick;
            err        <= err_in;
            dv         <= dv_in;
            weight     <= in_ch.output_tick + TICK_W'(1) - in_ch.sample_tick;
            dt         <= in_ch.sample_tick - cur_stamp;
            sat_acc    <= 1'b0;
            zdt        <= 1'b0;
            i_term     <= '0;
            d_term     <= '0;
            op         <= OP_P;
            state      <= S_LOAD;
          end
        end

        // set up the multiplier for the next product
        S_LOAD: begin
          mul_hi <= '0;
          cnt    <= '0;
          unique case (op)
            OP_P: begin
              mcand   <= MCAND_W'(err_mag);
              mul_lo  <= gp_mag;
              mul_neg <= err[ERR_W-1] ^ gain_p[GAIN_W-1];
            end
            OP_W: begin
              mcand   <= MCAND_W'(err_mag);
              mul_lo  <= weight;
              mul_neg <= err[ERR_W-1];
            end
            OP_I: begin
              mcand   <= acc_mag;
              mul_lo  <= gi_mag;
              mul_neg <= acc[ACC_W-1] ^ gain_i[GAIN_W-1];
            end
            OP_D: begin
              mcand   <= MCAND_W'(dv_mag);
              mul_lo  <= gd_mag;
              mul_neg <= dv[ERR_W-1] ^ gain_d[GAIN_W-1];
            end
          endcase
          state <= S_MUL;
        end

        // one multiplier bit per cycle
        S_MUL: begin
          mul_hi <= mul_sum[MCAND_W:1];
          mul_lo <= {mul_sum[0], mul_lo[MPLR_W-1:1]};
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            state <= S_POST;
          end
        end

        // take the finished product
        S_POST: begin
          unique case (op)
            OP_P: begin
              p_term <= mul_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
              if (cur_vel == '0) begin
                state <= S_SUM;
              end else begin
                op    <= OP_W;
                state <= S_LOAD;
              end
            end
            OP_W: begin
              if (acc_ovf) begin
                acc     <= {acc_sum[ACC_W+1], {(ACC_W-1){~acc_sum[ACC_W+1]}}};
                sat_acc <= 1'b1;
              end else begin
                acc <= acc_sum[ACC_W-1:0];
              end
              op    <= OP_I;
              state <= S_LOAD;
            end
            OP_I: begin
              i_term <= mul_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});
              if (dt == '0) begin
                zdt   <= 1'b1;
                state <= S_SUM;
              end else begin
                op    <= OP_D;
                state <= S_LOAD;
              end
            end
            OP_D: begin
              div_rem <= '0;
              div_quo <= mul_prod[DIV_W-1:0];
              div_neg <= mul_neg;
              cnt     <= '0;
              state   <= S_DIV;
            end
          endcase
        end

        // one quotient bit per cycle
        S_DIV: begin
          if (!div_diff[TICK_W+1]) begin
            div_rem <= div_diff[TICK_W-1:0];
          end else begin
            div_rem <= div_shift[TICK_W-1:0];
          end
          div_quo <= {div_quo[DIV_W-2:0], ~div_diff[TICK_W+1]};
          cnt     <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DPOST;
          end
        end

        // floor shift of the truncated quotient
        S_DPOST: begin
          d_term <= div_neg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
          state  <= S_SUM;
        end

        // load the output register once it is free
        S_SUM: begin
          if (out_load) begin
            out_ch.drive_value   <= sum_ovf ? {sum[SUM_W-1], {(OUT_W-1){~sum[SUM_W-1]}}}
                                            : sum[OUT_W-1:0];
            out_ch.sum_saturated <= sat_acc || sum_ovf;
            out_ch.zero_interval <= zdt;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `TPVL_ASSERT_IMP(a_mul_cnt, state == S_MUL, cnt < CNT_W'(MUL_STEPS), "multiplier count overrun")
  `TPVL_ASSERT_IMP(a_div_cnt, state == S_DIV, cnt < CNT_W'(DIV_STEPS), "divider count overrun")
  `TPVL_ASSERT_IMP(a_zdt, (state == S_SUM) && zdt, (cur_stamp == prev_stamp) && (cur_vel != '0), "zero interval flag without equal stamps")
  `TPVL_ASSERT_IMP(a_dv_hist, state != S_IDLE, dv == ERR_W'(cur_vel) - ERR_W'(old_vel), "velocity change out of step with history")
  `TPVL_ASSERT_NXT(a_out_src, !out_ch.valid && (state != S_SUM), !out_ch.valid, "result shown without a finished sum")

endmodule
